// File: hdl/wtscr_pkg.sv
`timescale 1ns / 1ps

package wtscr_pkg;

  localparam int unsigned SUM_W      = 12;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned GW_W       = 6;
  localparam int unsigned SRCX_W     = 14;
  localparam int unsigned TADDR_W    = 21;
  localparam int unsigned ROW_W      = 6;
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned DIV_CNT_W  = 4;

  typedef enum logic [1:0] {
    CMD_WRITE_TEXT  = 2'd0,
    CMD_WRITE_ATLAS = 2'd1,
    CMD_RENDER      = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_TEXT_LENGTH  = 3'd0,
    CFG_GLYPH_WIDTH  = 3'd1,
    CFG_GLYPH_HEIGHT = 3'd2,
    CFG_FIRST_CODE   = 3'd3,
    CFG_ATLAS_WIDTH  = 3'd4,
    CFG_ROW_TOP      = 3'd5,
    CFG_SCROLL_PHASE = 3'd6
  } cfg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_GW,
    S_DIV_LEN,
    S_CODE,
    S_SRCX,
    S_ROWS
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [14:0] write_address;
    logic [7:0]  write_data;
    logic [9:0]  column_x;
  } in_word_t;

  typedef struct packed {
    logic [9:0]  pixel_x;
    logic [10:0] pixel_y;
    logic [7:0]  color;
    logic        opaque;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [LEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
    logic [LEN_W-1:0] remainder;
  } div_rsp_t;

endpackage

// File: hdl/wrapping_text_scroll_column_renderer_core.sv
`timescale 1ns / 1ps

// Scrolling text column renderer. Write words load the text store (command 0) and the
// glyph atlas (command 1). A render word (command 2) is set up by two passes of the
// shared bit-serial divider (sample column over glyph width, then glyph slot over text
// length), one text store read and the atlas address calculation. After that the atlas
// memory port delivers one glyph row per cycle while the output side takes words. A
// column off screen is taken with no words; one whose glyph code lies before the first
// glyph code or whose source column lies beyond the atlas width ends after set-up with
// no words. Both stores hold no reset contents and need no clearing after reset.
// The user must write configuration only while the block is idle; it is not enforced.

module wrapping_text_scroll_column_renderer_core #(
  parameter int unsigned TEXT_DEPTH       = 64,
  parameter int unsigned ATLAS_DEPTH      = 32768,
  parameter int unsigned MAX_GLYPH_HEIGHT = 32,
  parameter int unsigned SCREEN_WIDTH     = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  wtscr_pkg::in_word_t                  in_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output wtscr_pkg::out_word_t                 out_word_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [wtscr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wtscr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned TAW  = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
  localparam int unsigned AAW  = (ATLAS_DEPTH > 1) ? $clog2(ATLAS_DEPTH) : 1;
  localparam int unsigned SW   = wtscr_pkg::SUM_W;
  localparam int unsigned LW   = wtscr_pkg::LEN_W;
  localparam int unsigned GW   = wtscr_pkg::GW_W;
  localparam int unsigned XW   = wtscr_pkg::SRCX_W;
  localparam int unsigned TW   = wtscr_pkg::TADDR_W;
  localparam int unsigned RW   = wtscr_pkg::ROW_W;
  localparam int unsigned CDW  = wtscr_pkg::CODE_W;
  localparam int unsigned IW   = wtscr_pkg::IDX_W;

  // configuration
  logic [6:0]  text_length_q;
  logic [5:0]  glyph_width_q;
  logic [5:0]  glyph_height_q;
  logic [7:0]  first_code_q;
  logic [12:0] atlas_width_q;
  logic [9:0]  row_top_q;
  logic [10:0] scroll_phase_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_length_q  <= 7'd1;
      glyph_width_q  <= 6'd16;
      glyph_height_q <= 6'd16;
      first_code_q   <= 8'd32;
      atlas_width_q  <= 13'd1536;
      row_top_q      <= '0;
      scroll_phase_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (wtscr_pkg::cfg_e'(cfg_index_i))
        wtscr_pkg::CFG_TEXT_LENGTH:  text_length_q  <= cfg_data_i[6:0];
        wtscr_pkg::CFG_GLYPH_WIDTH:  glyph_width_q  <= cfg_data_i[5:0];
        wtscr_pkg::CFG_GLYPH_HEIGHT: glyph_height_q <= cfg_data_i[5:0];
        wtscr_pkg::CFG_FIRST_CODE:   first_code_q   <= cfg_data_i[7:0];
        wtscr_pkg::CFG_ATLAS_WIDTH:  atlas_width_q  <= cfg_data_i[12:0];
        wtscr_pkg::CFG_ROW_TOP:      row_top_q      <= cfg_data_i[9:0];
        wtscr_pkg::CFG_SCROLL_PHASE: scroll_phase_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // effective settings
  logic [LW-1:0] len_nz, len_c;
  logic [GW-1:0] gw_c, gh_c;

  assign len_nz = (text_length_q == '0) ? LW'(1) : text_length_q;
  assign len_c  = (32'(len_nz) > TEXT_DEPTH) ? LW'(TEXT_DEPTH) : len_nz;
  assign gw_c   = (glyph_width_q == '0) ? GW'(1) : glyph_width_q;
  assign gh_c   = (32'(glyph_height_q) > MAX_GLYPH_HEIGHT) ? GW'(MAX_GLYPH_HEIGHT)
                                                           : glyph_height_q;

  // stores
  logic           in_acc;
  logic           t_we, a_we, t_re, a_re;
  logic [TAW-1:0] t_waddr, t_raddr;
  logic [AAW-1:0] a_waddr, a_raddr;
  logic [CDW-1:0] t_rdata, a_rdata;
  logic [TW-1:0]  wa_ext;
  logic [IW-1:0]  idx_ext;

  wtscr_pkg::div_req_t div_req;
  wtscr_pkg::div_rsp_t div_rsp;

  assign in_acc  = in_valid_i && in_ready_o;
  assign wa_ext  = TW'(in_word_i.write_address);
  assign t_we    = in_acc && (in_word_i.command == wtscr_pkg::CMD_WRITE_TEXT)
                   && (32'(in_word_i.write_address) < TEXT_DEPTH);
  assign a_we    = in_acc && (in_word_i.command == wtscr_pkg::CMD_WRITE_ATLAS)
                   && (32'(in_word_i.write_address) < ATLAS_DEPTH);
  assign t_waddr = wa_ext[TAW-1:0];
  assign a_waddr = wa_ext[AAW-1:0];
  assign idx_ext = IW'(div_rsp.remainder);
  assign t_raddr = idx_ext[TAW-1:0];

  wtscr_ram #(
    .WIDTH (CDW),
    .DEPTH (TEXT_DEPTH)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (in_word_i.write_data),
    .re_i    (t_re),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  wtscr_ram #(
    .WIDTH (CDW),
    .DEPTH (ATLAS_DEPTH)
  ) u_atlas_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (in_word_i.write_data),
    .re_i    (a_re),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  wtscr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer
  wtscr_pkg::state_e state_q, state_d;
  logic [9:0]    x_q, x_d;
  logic [GW-1:0] gh_q, gh_d;
  logic [GW-1:0] rem_gw_q, rem_gw_d;
  logic [XW-1:0] prod_q, prod_d;
  logic [TW-1:0] taddr_q, taddr_d;
  logic [RW-1:0] row_q, row_d;
  logic          pend_q, pend_d;
  logic          pend_in_q, pend_in_d;
  logic [9:0]    pend_x_q, pend_x_d;
  logic [10:0]   pend_y_q, pend_y_d;
  logic          pend_last_q, pend_last_d;
  logic          out_valid_q, out_valid_d;
  wtscr_pkg::out_word_t out_q, out_d;

  logic          render_ok;
  logic          load, issue, in_range, row_last;
  logic [XW-1:0] srcx;
  logic [CDW-1:0] color;

  assign in_ready_o = (state_q == wtscr_pkg::S_IDLE);
  assign render_ok  = (in_word_i.command == wtscr_pkg::CMD_RENDER)
                      && (32'(in_word_i.column_x) < SCREEN_WIDTH) && (gh_c != '0);
  assign load       = pend_q && (!out_valid_q || out_ready_i);
  assign issue      = (state_q == wtscr_pkg::S_ROWS) && (!pend_q || load);
  assign in_range   = 32'(taddr_q) < ATLAS_DEPTH;
  assign row_last   = row_q == (gh_q - RW'(1));
  assign a_re       = issue && in_range;
  assign a_raddr    = taddr_q[AAW-1:0];
  assign srcx       = prod_q + XW'(rem_gw_q);
  assign color      = pend_in_q ? a_rdata : '0;

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    gh_d        = gh_q;
    rem_gw_d    = rem_gw_q;
    prod_d      = prod_q;
    taddr_d     = taddr_q;
    row_d       = row_q;
    t_re        = 1'b0;
    div_req     = '0;
    pend_in_d   = pend_in_q;
    pend_x_d    = pend_x_q;
    pend_y_d    = pend_y_q;
    pend_last_d = pend_last_q;

    unique case (state_q)
      wtscr_pkg::S_IDLE: begin
        if (in_acc && render_ok) begin
          x_d              = in_word_i.column_x;
          gh_d             = gh_c;
          div_req.start    = 1'b1;
          div_req.dividend = SW'(in_word_i.column_x) + SW'(scroll_phase_q);
          div_req.divisor  = LW'(gw_c);
          state_d          = wtscr_pkg::S_DIV_GW;
        end
      end
      wtscr_pkg::S_DIV_GW: begin
        if (div_rsp.done) begin
          rem_gw_d         = div_rsp.remainder[GW-1:0];
          div_req.start    = 1'b1;
          div_req.dividend = div_rsp.quotient;
          div_req.divisor  = len_c;
          state_d          = wtscr_pkg::S_DIV_LEN;
        end
      end
      wtscr_pkg::S_DIV_LEN: begin
        if (div_rsp.done) begin
          t_re    = 1'b1;
          state_d = wtscr_pkg::S_CODE;
        end
      end
      wtscr_pkg::S_CODE: begin
        if (t_rdata < first_code_q) begin
          state_d = wtscr_pkg::S_IDLE;
        end else begin
          prod_d  = XW'((t_rdata - first_code_q) * gw_c);
          state_d = wtscr_pkg::S_SRCX;
        end
      end
      wtscr_pkg::S_SRCX: begin
        if (srcx >= XW'(atlas_width_q)) begin
          state_d = wtscr_pkg::S_IDLE;
        end else begin
          taddr_d = TW'(srcx);
          row_d   = '0;
          state_d = wtscr_pkg::S_ROWS;
        end
      end
      wtscr_pkg::S_ROWS: begin
        if (issue) begin
          pend_in_d   = in_range;
          pend_x_d    = x_q;
          pend_y_d    = 11'(row_top_q) + 11'(row_q);
          pend_last_d = row_last;
          taddr_d     = taddr_q + TW'(atlas_width_q);
          row_d       = row_q + RW'(1);
          if (row_last) begin
            state_d = wtscr_pkg::S_IDLE;
          end
        end
      end
      default: state_d = wtscr_pkg::S_IDLE;
    endcase

    pend_d = issue ? 1'b1 : (load ? 1'b0 : pend_q);

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load) begin
      out_valid_d    = 1'b1;
      out_d.pixel_x  = pend_x_q;
      out_d.pixel_y  = pend_y_q;
      out_d.color    = color;
      out_d.opaque   = color != '0;
      out_d.last     = pend_last_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wtscr_pkg::S_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    gh_q        <= gh_d;
    rem_gw_q    <= rem_gw_d;
    prod_q      <= prod_d;
    taddr_q     <= taddr_d;
    row_q       <= row_d;
    pend_in_q   <= pend_in_d;
    pend_x_q    <= pend_x_d;
    pend_y_q    <= pend_y_d;
    pend_last_q <= pend_last_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// File: hdl/wtscr_ram.sv
`timescale 1ns / 1ps

module wtscr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/wtscr_div.sv
`timescale 1ns / 1ps

module wtscr_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wtscr_pkg::div_req_t req_i,
  output wtscr_pkg::div_rsp_t rsp_o
);

  localparam int unsigned NW = wtscr_pkg::SUM_W;
  localparam int unsigned DW = wtscr_pkg::LEN_W;
  localparam int unsigned CW = wtscr_pkg::DIV_CNT_W;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] div_q, div_d;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;

  assign shifted = {rem_q, quo_q[NW-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign ge      = shifted >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[NW-2:0], ge};
      rem_d = ge ? diff[DW-1:0] : shifted[DW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// File: hdl/wtscr_checker.sv
`timescale 1ns / 1ps

module wtscr_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input wtscr_pkg::in_word_t              in_word_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input wtscr_pkg::out_word_t             out_word_o
);

  // a stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.opaque == (out_word_o.color != '0)))
    else $error("opaque flag does not match color");

  // rows of one column follow each other
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_word_o.last |=>
      !out_valid_o || ((out_word_o.pixel_x == $past(out_word_o.pixel_x))
                       && (out_word_o.pixel_y == $past(out_word_o.pixel_y) + 11'd1)))
    else $error("glyph rows out of sequence");

  // the block stays ready after a store write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o
      && ((in_word_i.command == wtscr_pkg::CMD_WRITE_TEXT)
          || (in_word_i.command == wtscr_pkg::CMD_WRITE_ATLAS)) |=> in_ready_o)
    else $error("not ready after a store write");

endmodule

bind wrapping_text_scroll_column_renderer_core wtscr_checker u_checker (.*);
